// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round helpers for the MD5 hashing core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int WORD_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int WADDR_W    = 4;
    localparam int BITCNT_W   = 64;
    localparam int ROUND_W    = 6;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINAL  = 1'b1;

    localparam logic [BYTE_W-1:0] PAD_LEAD   = 8'h80;
    localparam logic [POS_W-1:0]  POS_LAST   = 6'd63;
    localparam logic [POS_W-1:0]  POS_LENGTH = 6'd56;
    localparam logic [BITCNT_W-1:0] BYTE_BITS = 64'd8;

    typedef logic [3:0][WORD_W-1:0] word4_t;

    localparam word4_t CHAIN_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic init;
    } cmp_ctrl_t;

    localparam logic [WORD_W-1:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [WADDR_W-1:0] msg_index(input logic [ROUND_W-1:0] rnd);
        logic [WADDR_W-1:0] i;
        logic [WADDR_W-1:0] g;
        i = rnd[WADDR_W-1:0];
        case (rnd[5:4])
            2'd0:    g = i;
            2'd1:    g = WADDR_W'((i << 2) + i + 4'd1);
            2'd2:    g = WADDR_W'((i << 1) + i + 4'd5);
            default: g = WADDR_W'((i << 3) - i);
        endcase
        return g;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [4:0] n);
        logic [5:0] rs;
        rs = 6'd32 - {1'b0, n};
        return (v << n) | (v >> rs);
    endfunction

endpackage

// ===== rtl/md5_in_if.sv =====
// ----------------------------------------------------------------------------
// md5_in_if
// Message channel: one absorb byte or a finalize request per transaction.
// ----------------------------------------------------------------------------
interface md5_in_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [md5_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ===== rtl/md5_out_if.sv =====
// ----------------------------------------------------------------------------
// md5_out_if
// Digest channel: four 32-bit digest words per transaction.
// ----------------------------------------------------------------------------
interface md5_out_if;
    logic                         valid;
    logic                         ready;
    logic [md5_pkg::WORD_W-1:0]   digest_word0;
    logic [md5_pkg::WORD_W-1:0]   digest_word1;
    logic [md5_pkg::WORD_W-1:0]   digest_word2;
    logic [md5_pkg::WORD_W-1:0]   digest_word3;

    modport source (output valid, output digest_word0, output digest_word1,
                    output digest_word2, output digest_word3, input ready);
    modport sink   (input valid, input digest_word0, input digest_word1,
                    input digest_word2, input digest_word3, output ready);
endinterface

// ===== rtl/md5_hash_core.sv =====
// ----------------------------------------------------------------------------
// md5_hash_core
// MD5 hashing core: absorbs one message byte per transaction and emits the
// digest on a finalize transaction.
// ----------------------------------------------------------------------------
// Absorb: the byte that fills a block starts a compression
//   (a word fetch, 64 rounds at one per cycle, then one chaining fold).
// Finalize: one padding/length byte per cycle up to the block end (9 to 72),
//   with a compression at each block end (one or two), then the load of the
//   digest register (delayed while an earlier digest is still waiting).
// Reset: chaining words to the MD5 initial values, byte position and bit
//   count to zero; the block buffer is not cleared.
module md5_hash_core (
    input  logic                clk,
    input  logic                rst_n,
    md5_in_if.sink              msg_in,
    md5_out_if.source           digest_out
);

    md5_pkg::seq_state_t                state_reg, state_next;
    logic [md5_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [md5_pkg::BITCNT_W-1:0]       bitcnt_reg, bitcnt_next;
    logic                               fin_reg, fin_next;
    logic                               first_reg, first_next;
    logic                               lenph_reg, lenph_next;
    logic                               last_reg, last_next;
    logic                               out_valid_reg, out_valid_next;
    md5_pkg::word4_t                    digest_reg;

    logic                               accept;
    logic                               can_load;
    logic                               load_out;
    logic                               wr_en;
    logic [md5_pkg::BYTE_W-1:0]         wr_byte;
    logic                               sel_len;
    logic [md5_pkg::BYTE_W-1:0]         pad_byte;
    md5_pkg::cmp_ctrl_t                 cmp_ctrl;
    logic                               cmp_done;
    md5_pkg::word4_t                    chain;
    logic [md5_pkg::WADDR_W-1:0]        rd_addr;
    logic [md5_pkg::WORD_W-1:0]         rd_data;

    assign accept   = msg_in.valid && msg_in.ready;
    assign can_load = !out_valid_reg || digest_out.ready;
    assign sel_len  = !first_reg && (lenph_reg || (pos_reg == md5_pkg::POS_LENGTH));

    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = md5_pkg::PAD_LEAD;
        end
        else if (sel_len)
        begin
            pad_byte = bitcnt_reg[{pos_reg[2:0], 3'b000} +: md5_pkg::BYTE_W];
        end
        else
        begin
            pad_byte = '0;
        end
    end

    md5_msg_buf u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg),
        .wr_byte (wr_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md5_compress u_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cmp_ctrl),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .done    (cmp_done),
        .chain   (chain)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (msg_in.operation == md5_pkg::OP_FINAL)
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                    else if (pos_reg == md5_pkg::POS_LAST)
                    begin
                        state_next = md5_pkg::ST_COMP;
                    end
                end
            end
            md5_pkg::ST_PAD:
            begin
                if (pos_reg == md5_pkg::POS_LAST)
                begin
                    state_next = md5_pkg::ST_COMP;
                end
            end
            md5_pkg::ST_COMP:
            begin
                if (cmp_done)
                begin
                    if (!fin_reg)
                    begin
                        state_next = md5_pkg::ST_IDLE;
                    end
                    else if (last_reg)
                    begin
                        state_next = md5_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_OUT:
            begin
                if (can_load)
                begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        msg_in.ready   = 1'b0;
        wr_en          = 1'b0;
        wr_byte        = msg_in.data_byte;
        cmp_ctrl.start = 1'b0;
        cmp_ctrl.init  = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            md5_pkg::ST_IDLE:
            begin
                msg_in.ready = 1'b1;
                if (msg_in.valid && (msg_in.operation == md5_pkg::OP_ABSORB))
                begin
                    wr_en          = 1'b1;
                    cmp_ctrl.start = (pos_reg == md5_pkg::POS_LAST);
                end
            end
            md5_pkg::ST_PAD:
            begin
                wr_en          = 1'b1;
                wr_byte        = pad_byte;
                cmp_ctrl.start = (pos_reg == md5_pkg::POS_LAST);
            end
            md5_pkg::ST_OUT:
            begin
                load_out      = can_load;
                cmp_ctrl.init = can_load;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        bitcnt_next    = bitcnt_reg;
        fin_next       = fin_reg;
        first_next     = first_reg;
        lenph_next     = lenph_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        if (wr_en)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if ((state_reg == md5_pkg::ST_IDLE) && accept)
        begin
            if (msg_in.operation == md5_pkg::OP_FINAL)
            begin
                fin_next   = 1'b1;
                first_next = 1'b1;
            end
            else
            begin
                bitcnt_next = bitcnt_reg + md5_pkg::BYTE_BITS;
            end
        end
        if (state_reg == md5_pkg::ST_PAD)
        begin
            first_next = 1'b0;
            if (sel_len)
            begin
                lenph_next = 1'b1;
                if (pos_reg == md5_pkg::POS_LAST)
                begin
                    last_next = 1'b1;
                end
            end
        end
        if (digest_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            bitcnt_next    = '0;
            fin_next       = 1'b0;
            lenph_next     = 1'b0;
            last_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= md5_pkg::ST_IDLE;
            pos_reg       <= '0;
            bitcnt_reg    <= '0;
            fin_reg       <= 1'b0;
            first_reg     <= 1'b0;
            lenph_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bitcnt_reg    <= bitcnt_next;
            fin_reg       <= fin_next;
            first_reg     <= first_next;
            lenph_reg     <= lenph_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            digest_reg <= chain;
        end
    end

    assign digest_out.valid        = out_valid_reg;
    assign digest_out.digest_word0 = digest_reg[0];
    assign digest_out.digest_word1 = digest_reg[1];
    assign digest_out.digest_word2 = digest_reg[2];
    assign digest_out.digest_word3 = digest_reg[3];

    a_start_at_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_ctrl.start |-> (wr_en && (pos_reg == md5_pkg::POS_LAST)))
        else $error("compression started before block end");

    a_no_write_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == md5_pkg::ST_COMP) |-> !wr_en)
        else $error("buffer written during compression");

    a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_done |-> (state_reg == md5_pkg::ST_COMP))
        else $error("compression done outside compress state");

    a_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> (pos_reg == '0))
        else $error("length bytes did not end on block boundary");

    a_clean_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> ((pos_reg == '0) && (bitcnt_reg == '0) && !fin_reg))
        else $error("state not cleared after digest");

endmodule

// ===== rtl/md5_msg_buf.sv =====
// ----------------------------------------------------------------------------
// md5_msg_buf
// 64-byte block buffer: byte-wide write port, word-wide registered read port.
// ----------------------------------------------------------------------------
module md5_msg_buf (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [md5_pkg::POS_W-1:0]       wr_addr,
    input  logic [md5_pkg::BYTE_W-1:0]      wr_byte,
    input  logic [md5_pkg::WADDR_W-1:0]     rd_addr,
    output logic [md5_pkg::WORD_W-1:0]      rd_data
);

    logic [3:0][md5_pkg::BYTE_W-1:0] mem [16];
    logic [md5_pkg::WORD_W-1:0]      rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[5:2]][wr_addr[1:0]] <= wr_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/md5_compress.sv =====
// ----------------------------------------------------------------------------
// md5_compress
// Chaining words and the 64-round compression, one round per cycle, with
// message words fetched from the block buffer in the cycle before each round.
// ----------------------------------------------------------------------------
module md5_compress (
    input  logic                            clk,
    input  logic                            rst_n,
    input  md5_pkg::cmp_ctrl_t              ctrl,
    output logic [md5_pkg::WADDR_W-1:0]     rd_addr,
    input  logic [md5_pkg::WORD_W-1:0]      rd_data,
    output logic                            done,
    output md5_pkg::word4_t                 chain
);

    md5_pkg::word4_t                    chain_reg, chain_next;
    logic [md5_pkg::WORD_W-1:0]         a_reg, b_reg, c_reg, d_reg;
    logic [md5_pkg::WORD_W-1:0]         a_next, b_next, c_next, d_next;
    logic [md5_pkg::ROUND_W-1:0]        cnt_reg, cnt_next;
    logic [md5_pkg::ROUND_W-1:0]        rnd_reg, rnd_next;
    logic                               issue_reg, issue_next;
    logic                               run_reg, run_next;
    logic                               fold_reg, fold_next;

    logic [md5_pkg::WORD_W-1:0]         f_val;
    logic [md5_pkg::WORD_W-1:0]         t_sum;
    logic [md5_pkg::WORD_W-1:0]         new_b;

    assign rd_addr = md5_pkg::msg_index(cnt_reg);

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_sum = a_reg + f_val + rd_data + md5_pkg::K_TAB[rnd_reg];
        new_b = md5_pkg::rotl(t_sum, md5_pkg::ROT_TAB[{rnd_reg[5:4], rnd_reg[1:0]}]) + b_reg;
    end

    always_comb
    begin
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        issue_next = issue_reg;
        run_next   = 1'b0;
        fold_next  = 1'b0;

        if (ctrl.start)
        begin
            a_next     = chain_reg[0];
            b_next     = chain_reg[1];
            c_next     = chain_reg[2];
            d_next     = chain_reg[3];
            cnt_next   = '0;
            issue_next = 1'b1;
        end
        else if (issue_reg)
        begin
            rnd_next = cnt_reg;
            run_next = 1'b1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == md5_pkg::POS_LAST)
            begin
                issue_next = 1'b0;
            end
        end

        if (run_reg)
        begin
            a_next = d_reg;
            b_next = new_b;
            c_next = b_reg;
            d_next = c_reg;
            if (rnd_reg == md5_pkg::POS_LAST)
            begin
                fold_next = 1'b1;
            end
        end

        if (fold_reg)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
        end

        if (ctrl.init)
        begin
            chain_next = md5_pkg::CHAIN_IV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= md5_pkg::CHAIN_IV;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            issue_reg <= 1'b0;
            run_reg   <= 1'b0;
            fold_reg  <= 1'b0;
        end
        else
        begin
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            issue_reg <= issue_next;
            run_reg   <= run_next;
            fold_reg  <= fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign done  = fold_reg;
    assign chain = chain_reg;

endmodule
